### rtl/core/mwd_pkg.sv
// Shared types and constants for the multiword by word divider.
// Used by mwd_ctrl, mwd_dpath and multiword_by_word_divider_unit.
// No dependencies.
`default_nettype none

package mwd_pkg;

    localparam int WordW = 64;
    localparam int HalfW = 32;
    localparam int ShiftW = 6;

    typedef logic [WordW-1:0] t_word;

    // Datapath operations, one per cycle
    localparam logic [3:0] OP_NONE  = 4'd0;
    localparam logic [3:0] OP_CFG   = 4'd1;   // load divisor, clear running remainder
    localparam logic [3:0] OP_NORM  = 4'd2;   // shift divisor left one bit
    localparam logic [3:0] OP_RINIT = 4'd3;   // start reciprocal division
    localparam logic [3:0] OP_RSTEP = 4'd4;   // one reciprocal quotient bit
    localparam logic [3:0] OP_LOAD  = 4'd5;   // take dividend word, align it
    localparam logic [3:0] OP_QEST  = 4'd6;   // quotient estimate from n1*inv
    localparam logic [3:0] OP_REM   = 4'd7;   // candidate remainder
    localparam logic [3:0] OP_FIX1  = 4'd8;   // first correction
    localparam logic [3:0] OP_FIX2  = 4'd9;   // second correction
    localparam logic [3:0] OP_OUT   = 4'd10;  // load output register

    // Partial product selects for the shared 32x32 multiplier
    localparam logic [2:0] MUL_N1L_IL = 3'd0;
    localparam logic [2:0] MUL_N1L_IH = 3'd1;
    localparam logic [2:0] MUL_N1H_IL = 3'd2;
    localparam logic [2:0] MUL_N1H_IH = 3'd3;
    localparam logic [2:0] MUL_QL_DL  = 3'd4;
    localparam logic [2:0] MUL_QL_DH  = 3'd5;
    localparam logic [2:0] MUL_QH_DL  = 3'd6;

    // State after reset: divisor 1, normalized
    localparam t_word DN_RESET = {1'b1, {(WordW-1){1'b0}}};
    localparam t_word INV_RESET = {WordW{1'b1}};
    localparam logic [ShiftW-1:0] SHIFT_RESET = {ShiftW{1'b1}};

    typedef struct packed {
        logic [3:0] op;
        logic       mul_go;
        logic [2:0] mul_idx;
    } t_cmd;

    typedef struct packed {
        logic dn_msb;       // normalized divisor has its top bit set
        logic cfg_nonzero;  // divisor write data is nonzero
    } t_sts;

endpackage

`default_nettype wire

### rtl/core/mwd_ctrl.sv
// Controller state machine for the multiword by word divider.
// Depends on mwd_pkg; drives mwd_dpath through t_cmd.
`default_nettype none

module mwd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    input  wire logic          i_cfg_wr_en,
    input  wire mwd_pkg::t_sts i_sts,
    output mwd_pkg::t_cmd      o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_NORM  = 4'd1;
    localparam logic [3:0] S_RECIP = 4'd2;
    localparam logic [3:0] S_MUL1  = 4'd3;
    localparam logic [3:0] S_QEST  = 4'd4;
    localparam logic [3:0] S_MUL2  = 4'd5;
    localparam logic [3:0] S_REM   = 4'd6;
    localparam logic [3:0] S_FIX1  = 4'd7;
    localparam logic [3:0] S_FIX2  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0] r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;
    logic       w_in_acc;

    // Input taken only when idle and no divisor write is in flight
    assign o_in_stall = (r_state != S_IDLE) || i_cfg_wr_en;
    assign w_in_acc = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd = '0;
        o_cmd.op = mwd_pkg::OP_NONE;
        o_cmd.mul_idx = mwd_pkg::MUL_N1L_IL;
        if (i_cfg_wr_en && i_sts.cfg_nonzero) begin
            o_cmd.op = mwd_pkg::OP_CFG;
            n_state = S_NORM;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        o_cmd.op = mwd_pkg::OP_LOAD;
                        n_state = S_MUL1;
                        n_cnt = '0;
                    end
                end
                S_NORM: begin
                    if (i_sts.dn_msb) begin
                        o_cmd.op = mwd_pkg::OP_RINIT;
                        n_state = S_RECIP;
                        n_cnt = '0;
                    end else begin
                        o_cmd.op = mwd_pkg::OP_NORM;
                    end
                end
                S_RECIP: begin
                    o_cmd.op = mwd_pkg::OP_RSTEP;
                    if (r_cnt == 6'd63) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + 6'd1;
                    end
                end
                // n1 * inv: four products, then a pass with no product while the last one accumulates
                S_MUL1: begin
                    if (r_cnt == 6'd4) begin
                        n_state = S_QEST;
                    end else begin
                        o_cmd.mul_go = 1'b1;
                        n_cnt = r_cnt + 6'd1;
                        case (r_cnt[1:0])
                            2'd0: o_cmd.mul_idx = mwd_pkg::MUL_N1L_IL;
                            2'd1: o_cmd.mul_idx = mwd_pkg::MUL_N1L_IH;
                            2'd2: o_cmd.mul_idx = mwd_pkg::MUL_N1H_IL;
                            2'd3: o_cmd.mul_idx = mwd_pkg::MUL_N1H_IH;
                            default: o_cmd.mul_idx = mwd_pkg::MUL_N1L_IL;
                        endcase
                    end
                end
                S_QEST: begin
                    o_cmd.op = mwd_pkg::OP_QEST;
                    n_state = S_MUL2;
                    n_cnt = '0;
                end
                // low half of qh * dn: three products
                S_MUL2: begin
                    if (r_cnt == 6'd3) begin
                        n_state = S_REM;
                    end else begin
                        o_cmd.mul_go = 1'b1;
                        n_cnt = r_cnt + 6'd1;
                        case (r_cnt[1:0])
                            2'd0: o_cmd.mul_idx = mwd_pkg::MUL_QL_DL;
                            2'd1: o_cmd.mul_idx = mwd_pkg::MUL_QL_DH;
                            2'd2: o_cmd.mul_idx = mwd_pkg::MUL_QH_DL;
                            default: o_cmd.mul_idx = mwd_pkg::MUL_QL_DL;
                        endcase
                    end
                end
                S_REM: begin
                    o_cmd.op = mwd_pkg::OP_REM;
                    n_state = S_FIX1;
                end
                S_FIX1: begin
                    o_cmd.op = mwd_pkg::OP_FIX1;
                    n_state = S_FIX2;
                end
                S_FIX2: begin
                    o_cmd.op = mwd_pkg::OP_FIX2;
                    n_state = S_OUT;
                end
                // wait for the output register to free up
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        o_cmd.op = mwd_pkg::OP_OUT;
                        n_out_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

### rtl/core/mwd_dpath.sv
// Datapath for the multiword by word divider: divisor normalization,
// reciprocal division, shared 32x32 multiplier, corrections, output register.
// Depends on mwd_pkg; commanded by mwd_ctrl.
`default_nettype none

module mwd_dpath (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire mwd_pkg::t_cmd         i_cmd,
    output mwd_pkg::t_sts              o_sts,
    input  wire logic [63:0]           i_cfg_wr_data,
    input  wire logic [63:0]           i_dividend_word,
    input  wire logic                  i_last_word,
    output logic [63:0]                o_quotient_word,
    output logic [63:0]                o_remainder_out,
    output logic                       o_end_flag
);

    // Divisor state
    mwd_pkg::t_word r_dn;       // normalized divisor
    logic [mwd_pkg::ShiftW-1:0] r_shift;
    mwd_pkg::t_word r_inv;      // reciprocal, built one bit a cycle
    mwd_pkg::t_word r_rc;       // partial remainder of the reciprocal division
    mwd_pkg::t_word r_rem;      // running remainder, not normalized

    // Per-word working registers
    mwd_pkg::t_word r_n1, r_n0, r_qh, r_ql, r_r;
    logic           r_last;
    logic [127:0]   r_acc;

    // Multiplier pipeline
    logic [63:0]    r_prod;
    logic           r_pv;
    logic [1:0]     r_pshift, w_pshift;
    logic [31:0]    w_mul_a, w_mul_b;
    logic [63:0]    w_prod;
    logic [127:0]   w_prod_al;

    // Output register
    mwd_pkg::t_word r_q_out, r_rem_out;
    logic           r_end_out;

    logic [127:0]   w_nshift;
    logic [63:0]    w_rc_sh;
    logic           w_take;
    logic [64:0]    w_ql_sum;
    mwd_pkg::t_word w_qh_sum;
    mwd_pkg::t_word w_rem_dn;

    assign o_sts.dn_msb = r_dn[63];
    assign o_sts.cfg_nonzero = (i_cfg_wr_data != '0);

    // Align remainder:word to the normalized divisor
    assign w_nshift = {r_rem, i_dividend_word} << r_shift;

    // Restoring division step for the reciprocal
    assign w_rc_sh = {r_rc[62:0], 1'b1};
    assign w_take = r_rc[63] || (w_rc_sh >= r_dn);

    // Quotient estimate sums
    assign w_ql_sum = {1'b0, r_acc[63:0]} + {1'b0, r_n0};
    assign w_qh_sum = r_acc[127:64] + r_n1 + 64'(w_ql_sum[64]) + 64'd1;

    assign w_rem_dn = r_r >> r_shift;

    // Operand select for the shared multiplier
    always_comb begin
        case (i_cmd.mul_idx)
            mwd_pkg::MUL_N1L_IL: begin
                w_mul_a = r_n1[31:0];  w_mul_b = r_inv[31:0];  w_pshift = 2'd0;
            end
            mwd_pkg::MUL_N1L_IH: begin
                w_mul_a = r_n1[31:0];  w_mul_b = r_inv[63:32]; w_pshift = 2'd1;
            end
            mwd_pkg::MUL_N1H_IL: begin
                w_mul_a = r_n1[63:32]; w_mul_b = r_inv[31:0];  w_pshift = 2'd1;
            end
            mwd_pkg::MUL_N1H_IH: begin
                w_mul_a = r_n1[63:32]; w_mul_b = r_inv[63:32]; w_pshift = 2'd2;
            end
            mwd_pkg::MUL_QL_DL: begin
                w_mul_a = r_qh[31:0];  w_mul_b = r_dn[31:0];   w_pshift = 2'd0;
            end
            mwd_pkg::MUL_QL_DH: begin
                w_mul_a = r_qh[31:0];  w_mul_b = r_dn[63:32];  w_pshift = 2'd1;
            end
            mwd_pkg::MUL_QH_DL: begin
                w_mul_a = r_qh[63:32]; w_mul_b = r_dn[31:0];   w_pshift = 2'd1;
            end
            default: begin
                w_mul_a = r_n1[31:0];  w_mul_b = r_inv[31:0];  w_pshift = 2'd0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // Place the registered product at its 32-bit column
    always_comb begin
        case (r_pshift)
            2'd0: w_prod_al = {64'd0, r_prod};
            2'd1: w_prod_al = {32'd0, r_prod, 32'd0};
            2'd2: w_prod_al = {r_prod, 64'd0};
            default: w_prod_al = {64'd0, r_prod};
        endcase
    end

    // Multiplier output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.mul_go;
        end
        if (i_cmd.mul_go) begin
            r_prod <= w_prod;
            r_pshift <= w_pshift;
        end
    end

    // Accumulator: cleared at word load and after the estimate
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == mwd_pkg::OP_LOAD || i_cmd.op == mwd_pkg::OP_QEST) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_acc + w_prod_al;
        end
    end

    // Divisor, reciprocal and running remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dn <= mwd_pkg::DN_RESET;
            r_shift <= mwd_pkg::SHIFT_RESET;
            r_inv <= mwd_pkg::INV_RESET;
            r_rem <= '0;
        end else begin
            case (i_cmd.op)
                mwd_pkg::OP_CFG: begin
                    r_dn <= i_cfg_wr_data;
                    r_shift <= '0;
                    r_rem <= '0;
                end
                mwd_pkg::OP_NORM: begin
                    r_dn <= {r_dn[62:0], 1'b0};
                    r_shift <= r_shift + 6'd1;
                end
                mwd_pkg::OP_RSTEP: begin
                    r_inv <= {r_inv[62:0], w_take};
                end
                mwd_pkg::OP_OUT: begin
                    r_rem <= r_last ? '0 : w_rem_dn;
                end
                default: begin
                end
            endcase
        end
    end

    // Reciprocal partial remainder and per-word working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            mwd_pkg::OP_RINIT: begin
                r_rc <= ~r_dn;
            end
            mwd_pkg::OP_RSTEP: begin
                r_rc <= w_take ? (w_rc_sh - r_dn) : w_rc_sh;
            end
            mwd_pkg::OP_LOAD: begin
                r_n1 <= w_nshift[127:64];
                r_n0 <= w_nshift[63:0];
                r_last <= i_last_word;
            end
            mwd_pkg::OP_QEST: begin
                r_ql <= w_ql_sum[63:0];
                r_qh <= w_qh_sum;
            end
            mwd_pkg::OP_REM: begin
                r_r <= r_n0 - r_acc[63:0];
            end
            mwd_pkg::OP_FIX1: begin
                if (r_r > r_ql) begin
                    r_qh <= r_qh - 64'd1;
                    r_r <= r_r + r_dn;
                end
            end
            mwd_pkg::OP_FIX2: begin
                if (r_r >= r_dn) begin
                    r_qh <= r_qh + 64'd1;
                    r_r <= r_r - r_dn;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == mwd_pkg::OP_OUT) begin
            r_q_out <= r_qh;
            r_rem_out <= r_last ? w_rem_dn : '0;
            r_end_out <= r_last;
        end
    end

    assign o_quotient_word = r_q_out;
    assign o_remainder_out = r_rem_out;
    assign o_end_flag = r_end_out;

endmodule

`default_nettype wire

### rtl/core/multiword_by_word_divider_unit.sv
// Top level of the multiword by word divider.
// Depends on mwd_pkg, mwd_ctrl and mwd_dpath.
//
//  Channel  Handshake                  Payload
//  -------  -------------------------  ------------------------------------------
//  in       i_in_valid / o_in_stall    i_dividend_word, i_last_word
//  out      o_out_valid / i_out_stall  o_quotient_word, o_remainder_out, o_end_flag
//  cfg      i_cfg_wr_en                i_cfg_wr_data (divisor, zero is ignored)
//
// Each word goes from acceptance to the output register through the seven
// 32x32 partial products (n1*inv, then qh*dn) on the one multiplier, with an
// accumulate step after each product run, then estimate, remainder, two
// corrections and the output load, held while the output register is full.
// Reset (synchronous, active low) loads divisor 1 with its reciprocal.
// A nonzero divisor write stalls the input through normalization, one bit
// per cycle, then through the reciprocal division, one reciprocal bit per cycle.
// The next word is accepted while a result waits in the output register.
`default_nettype none

module multiword_by_word_divider_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [63:0] i_dividend_word,
    input  wire logic        i_last_word,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [63:0]      o_quotient_word,
    output logic [63:0]      o_remainder_out,
    output logic             o_end_flag,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [63:0] i_cfg_wr_data
);

    mwd_pkg::t_cmd w_cmd;
    mwd_pkg::t_sts w_sts;

    mwd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    mwd_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_dividend_word (i_dividend_word),
        .i_last_word     (i_last_word),
        .o_quotient_word (o_quotient_word),
        .o_remainder_out (o_remainder_out),
        .o_end_flag      (o_end_flag)
    );

endmodule

`default_nettype wire
